// ----- sv/gmp_pkg.sv -----
package gmp_pkg;

   localparam int MAZE_WIDTH   = 16;
   localparam int MAZE_HEIGHT  = 16;
   localparam int ACTION_DEPTH = 512;

   localparam int CELL_COUNT = MAZE_WIDTH * MAZE_HEIGHT;
   localparam int XY_W  = $clog2((MAZE_WIDTH > MAZE_HEIGHT) ? MAZE_WIDTH : MAZE_HEIGHT);
   localparam int CELL_W = $clog2(CELL_COUNT);
   localparam int LEN_W  = $clog2(CELL_COUNT + 1);
   localparam int ACT_W  = $clog2(ACTION_DEPTH);
   localparam int TOT_W  = $clog2(ACTION_DEPTH + 1);
   localparam int DIST_W = 9;
   localparam logic [DIST_W-1:0] DIST_INF = '1;

   typedef logic [XY_W-1:0]   xy_type;
   typedef logic [CELL_W-1:0] cell_type;

   typedef enum logic [1:0] {
      OP_REOPEN = 2'd0,
      OP_WALL   = 2'd1,
      OP_PLAN   = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SIDE_NORTH = 2'd0,
      SIDE_SOUTH = 2'd1,
      SIDE_EAST  = 2'd2,
      SIDE_WEST  = 2'd3
   } side_type;

   localparam logic [1:0] MOVE_LEFT  = 2'd0;
   localparam logic [1:0] MOVE_RIGHT = 2'd1;
   localparam logic [1:0] MOVE_FWD   = 2'd2;
   localparam logic [1:0] MOVE_NONE  = 2'd3;

   typedef enum logic [1:0] {
      KIND_FWD   = 2'd0,
      KIND_BACK  = 2'd1,
      KIND_LEFT  = 2'd2,
      KIND_RIGHT = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [3:0] cell_x;
      logic [3:0] cell_y;
      logic [1:0] wall_side;
      logic [3:0] source_x;
      logic [3:0] source_y;
      logic [3:0] target_x;
      logic [3:0] target_y;
      logic [1:0] heading;
      logic [8:0] action_index;
   } req_payload_type;

   typedef struct packed {
      logic [9:0] action_count;
      logic       target_reached;
      logic [1:0] move_code;
   } rsp_payload_type;

   // one search record per cell
   typedef struct packed {
      logic              settled;
      logic              pred_valid;
      logic [1:0]        pred_side;
      logic [DIST_W-1:0] distance;
   } node_type;

   typedef struct packed {
      logic   ok;
      xy_type x;
      xy_type y;
   } step_type;

   function automatic cell_type cell_addr(xy_type x, xy_type y);
      return CELL_W'(int'(x) * MAZE_HEIGHT + int'(y));
   endfunction

   function automatic step_type step_cell(xy_type x, xy_type y, logic [1:0] side);
      step_type s;
      s.x  = x;
      s.y  = y;
      s.ok = 1'b0;
      case (side)
         SIDE_NORTH: begin
            s.ok = (int'(y) + 1) < MAZE_HEIGHT;
            s.y  = XY_W'(int'(y) + 1);
         end
         SIDE_SOUTH: begin
            s.ok = (y != '0);
            s.y  = XY_W'(int'(y) - 1);
         end
         SIDE_EAST: begin
            s.ok = (int'(x) + 1) < MAZE_WIDTH;
            s.x  = XY_W'(int'(x) + 1);
         end
         default: begin
            s.ok = (x != '0);
            s.x  = XY_W'(int'(x) - 1);
         end
      endcase
      return s;
   endfunction

   function automatic logic [3:0] passage_init(xy_type x, xy_type y);
      logic [3:0] bits;
      for (int s = 0; s < 4; s++) begin
         bits[s] = step_cell(x, y, 2'(s)).ok;
      end
      return bits;
   endfunction

   // turn needed to go toward dir while facing head
   function automatic kind_type move_kind(logic [1:0] dir, logic [1:0] head);
      kind_type k;
      if (dir == head) begin
         k = KIND_FWD;
      end else if (dir == (head ^ 2'd1)) begin
         k = KIND_BACK;
      end else begin
         case ({dir, head})
            {SIDE_NORTH, SIDE_EAST}, {SIDE_SOUTH, SIDE_WEST},
            {SIDE_EAST, SIDE_SOUTH}, {SIDE_WEST, SIDE_NORTH}: k = KIND_LEFT;
            default: k = KIND_RIGHT;
         endcase
      end
      return k;
   endfunction

endpackage

// ----- sv/gmp_req_if.sv -----
interface gmp_req_if;
   logic                     valid;
   logic                     ready;
   gmp_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/gmp_rsp_if.sv -----
interface gmp_rsp_if;
   logic                     valid;
   logic                     ready;
   gmp_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/grid_maze_path_planner.sv -----
// Steps from accept to result: add wall writes the cell's side, then the neighbor's facing
// side (skipped on a border side); read fetches the stored action; reopen sweeps every cell.
// Plan: init every cell, then per selection scan every cell, settle and fetch the map and
// relax the open neighbors; then trace the path back from the target, emit, and respond.
// Throughput: one transaction at a time; the next is taken once the result is accepted.
// Reset: synchronous; a sweep over every cell reloads the passage map, taking no transaction.
module grid_maze_path_planner (
   input logic clock,
   input logic reset,
   gmp_req_if.sink   req_chan,
   gmp_rsp_if.source rsp_chan
);
   import gmp_pkg::*;

   typedef enum logic [15:0] {
      S_CLEAR   = 16'h0001,
      S_IDLE    = 16'h0002,
      S_WALL_1  = 16'h0004,
      S_WALL_2  = 16'h0008,
      S_READ    = 16'h0010,
      S_INIT    = 16'h0020,
      S_SCAN    = 16'h0040,
      S_SCANEND = 16'h0080,
      S_SELECT  = 16'h0100,
      S_PASS    = 16'h0200,
      S_NBR_RD  = 16'h0400,
      S_NBR_WR  = 16'h0800,
      S_TRC_RD  = 16'h1000,
      S_TRC_WR  = 16'h2000,
      S_EMIT_RD = 16'h4000,
      S_EMIT    = 16'h8000
   } state_type;

   // memories
   logic [3:0]  pass_mem [CELL_COUNT];
   node_type    node_mem [CELL_COUNT];
   logic [1:0]  path_mem [CELL_COUNT];
   logic [1:0]  act_mem  [ACTION_DEPTH];

   logic pass_we, node_we, path_we, act_we;
   cell_type pass_waddr, pass_raddr, node_waddr, node_raddr, path_waddr, path_raddr;
   logic [ACT_W-1:0] act_waddr, act_raddr;
   logic [3:0] pass_wdata, pass_rdata_ff;
   node_type   node_wdata, node_rdata_ff;
   logic [1:0] path_wdata, path_rdata_ff, act_wdata, act_rdata_ff;

   always_ff @(posedge clock) begin
      if (pass_we) pass_mem[pass_waddr] <= pass_wdata;
      pass_rdata_ff <= pass_mem[pass_raddr];
      if (node_we) node_mem[node_waddr] <= node_wdata;
      node_rdata_ff <= node_mem[node_raddr];
      if (path_we) path_mem[path_waddr] <= path_wdata;
      path_rdata_ff <= path_mem[path_raddr];
      if (act_we) act_mem[act_waddr] <= act_wdata;
      act_rdata_ff <= act_mem[act_raddr];
   end

   state_type state_ff, state_in;
   xy_type x_ff, x_in, y_ff, y_in;           // sweep and scan position
   xy_type ev_x_ff, ev_x_in, ev_y_ff, ev_y_in;
   logic   ev_valid_ff, ev_valid_in;
   logic [DIST_W-1:0] bd_ff, bd_in;           // least distance so far
   xy_type bx_ff, bx_in, by_ff, by_in;        // chosen cell, later the trace cursor
   node_type bw_ff, bw_in;
   logic   any_ff, any_in;
   logic [1:0] side_ff, side_in;
   logic [3:0] open_ff, open_in;
   xy_type nx_ff, nx_in, ny_ff, ny_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic   found_ff, found_in;
   logic [1:0] head_ff, head_in, dir_ff, dir_in, sub_ff, sub_in;
   kind_type kind_ff, kind_in;
   xy_type sx_ff, sx_in, sy_ff, sy_in, tx_ff, tx_in, ty_ff, ty_in;
   xy_type cx_ff, cx_in, cy_ff, cy_in;
   logic [1:0] wside_ff, wside_in;
   logic [8:0] idx_ff, idx_in;
   logic   pend_ff, pend_in;
   logic   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic [1:0] code_ff, code_in;

   logic accept;
   req_payload_type rq;
   step_type st;
   logic [DIST_W:0] alt;
   logic [LEN_W-1:0] len_dec;
   logic [1:0] emit_code;
   logic emit_last;
   logic x_last, y_last;

   assign rq     = req_chan.payload;
   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   assign alt     = {1'b0, bd_ff} + 1'b1;
   assign len_dec = len_ff - 1'b1;
   assign x_last  = int'(x_ff) == MAZE_WIDTH - 1;
   assign y_last  = int'(y_ff) == MAZE_HEIGHT - 1;

   // action sequence per turn kind
   always_comb begin
      emit_code = MOVE_FWD;
      emit_last = 1'b1;
      case (kind_ff)
         KIND_BACK: begin
            emit_code = (sub_ff == 2'd2) ? MOVE_FWD : MOVE_RIGHT;
            emit_last = (sub_ff == 2'd2);
         end
         KIND_LEFT: begin
            emit_code = (sub_ff == 2'd1) ? MOVE_FWD : MOVE_LEFT;
            emit_last = (sub_ff == 2'd1);
         end
         KIND_RIGHT: begin
            emit_code = (sub_ff == 2'd1) ? MOVE_FWD : MOVE_RIGHT;
            emit_last = (sub_ff == 2'd1);
         end
         default: begin
            emit_code = MOVE_FWD;
            emit_last = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      x_in = x_ff;  y_in = y_ff;
      ev_x_in = ev_x_ff;  ev_y_in = ev_y_ff;  ev_valid_in = 1'b0;
      bd_in = bd_ff;  bx_in = bx_ff;  by_in = by_ff;  bw_in = bw_ff;  any_in = any_ff;
      side_in = side_ff;  open_in = open_ff;  nx_in = nx_ff;  ny_in = ny_ff;
      len_in = len_ff;  total_in = total_ff;  found_in = found_ff;
      head_in = head_ff;  dir_in = dir_ff;  sub_in = sub_ff;  kind_in = kind_ff;
      sx_in = sx_ff;  sy_in = sy_ff;  tx_in = tx_ff;  ty_in = ty_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  wside_in = wside_ff;  idx_in = idx_ff;
      pend_in = pend_ff;  code_in = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in = rsp_ff;

      pass_we = 1'b0;  pass_waddr = cell_addr(x_ff, y_ff);
      pass_wdata = passage_init(x_ff, y_ff);  pass_raddr = cell_addr(bx_ff, by_ff);
      node_we = 1'b0;  node_waddr = cell_addr(x_ff, y_ff);
      node_wdata = bw_ff;  node_raddr = cell_addr(x_ff, y_ff);
      path_we = 1'b0;  path_waddr = len_ff[CELL_W-1:0];
      path_wdata = 2'd0;  path_raddr = len_dec[CELL_W-1:0];
      act_we = 1'b0;  act_waddr = total_ff[ACT_W-1:0];
      act_wdata = emit_code;  act_raddr = ACT_W'(rq.action_index);
      st = step_cell(bx_ff, by_ff, side_ff);

      // fold the scanned entry into the running minimum; strict compare keeps
      // the earliest cell in scan order on ties
      if (ev_valid_ff && !node_rdata_ff.settled && node_rdata_ff.distance < bd_ff) begin
         bd_in  = node_rdata_ff.distance;
         bx_in  = ev_x_ff;
         by_in  = ev_y_ff;
         bw_in  = node_rdata_ff;
         any_in = 1'b1;
      end

      unique case (state_ff)
         S_CLEAR: begin
            // reload interior open, border closed
            pass_we = 1'b1;
            y_in = y_last ? '0 : y_ff + 1'b1;
            if (y_last) begin
               x_in = x_last ? '0 : x_ff + 1'b1;
               if (x_last) begin
                  state_in = pend_ff ? S_SELECT : S_IDLE;
                  pend_in  = 1'b0;
               end
            end
         end
         S_IDLE: begin
            code_in = MOVE_NONE;
            if (accept) begin
               cx_in = XY_W'(rq.cell_x);  cy_in = XY_W'(rq.cell_y);
               wside_in = rq.wall_side;
               sx_in = XY_W'(rq.source_x);  sy_in = XY_W'(rq.source_y);
               tx_in = XY_W'(rq.target_x);  ty_in = XY_W'(rq.target_y);
               head_in = rq.heading;
               idx_in = rq.action_index;
               x_in = '0;  y_in = '0;
               case (op_type'(rq.operation))
                  OP_REOPEN: begin
                     pend_in  = 1'b1;
                     state_in = S_CLEAR;
                  end
                  OP_WALL: begin
                     pass_raddr = cell_addr(XY_W'(rq.cell_x), XY_W'(rq.cell_y));
                     if (int'(rq.cell_x) < MAZE_WIDTH && int'(rq.cell_y) < MAZE_HEIGHT)
                        state_in = S_WALL_1;
                     else begin
                        any_in   = 1'b0;
                        state_in = S_SELECT;
                     end
                  end
                  OP_PLAN: begin
                     total_in = '0;
                     found_in = 1'b0;
                     any_in   = 1'b0;
                     if (int'(rq.source_x) < MAZE_WIDTH && int'(rq.source_y) < MAZE_HEIGHT
                         && int'(rq.target_x) < MAZE_WIDTH
                         && int'(rq.target_y) < MAZE_HEIGHT)
                        state_in = S_INIT;
                     else
                        state_in = S_SELECT;
                  end
                  default: begin
                     state_in = S_READ;
                  end
               endcase
            end
         end
         S_WALL_1: begin
            // close own side, then fetch the neighbor for its facing side
            pass_we    = 1'b1;
            pass_waddr = cell_addr(cx_ff, cy_ff);
            pass_wdata = pass_rdata_ff & ~(4'd1 << wside_ff);
            st = step_cell(cx_ff, cy_ff, wside_ff);
            nx_in = st.x;  ny_in = st.y;
            pass_raddr = cell_addr(st.x, st.y);
            any_in = 1'b0;
            state_in = st.ok ? S_WALL_2 : S_SELECT;
         end
         S_WALL_2: begin
            pass_we    = 1'b1;
            pass_waddr = cell_addr(nx_ff, ny_ff);
            pass_wdata = pass_rdata_ff & ~(4'd1 << (wside_ff ^ 2'd1));
            state_in   = S_SELECT;
         end
         S_READ: begin
            code_in  = (int'(idx_ff) < int'(total_ff)) ? act_rdata_ff : MOVE_NONE;
            any_in   = 1'b0;
            state_in = S_SELECT;
         end
         S_INIT: begin
            node_we = 1'b1;
            node_wdata.settled    = 1'b0;
            node_wdata.pred_valid = 1'b0;
            node_wdata.pred_side  = 2'd0;
            node_wdata.distance = (x_ff == sx_ff && y_ff == sy_ff) ? '0 : DIST_INF;
            y_in = y_last ? '0 : y_ff + 1'b1;
            if (y_last) begin
               x_in = x_last ? '0 : x_ff + 1'b1;
               if (x_last) begin
                  bd_in    = DIST_INF;
                  any_in   = 1'b0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // issue one read per cycle, x major then y
            ev_valid_in = 1'b1;
            ev_x_in = x_ff;  ev_y_in = y_ff;
            y_in = y_last ? '0 : y_ff + 1'b1;
            if (y_last) begin
               x_in = x_last ? '0 : x_ff + 1'b1;
               if (x_last) state_in = S_SCANEND;
            end
         end
         S_SCANEND: begin
            state_in = S_SELECT;
         end
         S_SELECT: begin
            // also the common exit: any_ff low finishes the transaction;
            // only a search reaches here with a candidate
            if (!any_ff || !(state_ff == S_SELECT)) begin
               if (!rsp_valid_in) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.action_count   = 10'(total_ff);
                  rsp_in.target_reached = found_ff;
                  rsp_in.move_code      = code_ff;
                  state_in = S_IDLE;
               end
            end else begin
               node_we    = 1'b1;
               node_waddr = cell_addr(bx_ff, by_ff);
               node_wdata = bw_ff;
               node_wdata.settled = 1'b1;
               pass_raddr = cell_addr(bx_ff, by_ff);
               if (bx_ff == tx_ff && by_ff == ty_ff) begin
                  found_in = 1'b1;
                  len_in   = '0;
                  any_in   = 1'b0;
                  state_in = S_TRC_RD;
               end else begin
                  state_in = S_PASS;
               end
            end
         end
         S_PASS: begin
            open_in  = pass_rdata_ff;
            side_in  = SIDE_NORTH;
            state_in = S_NBR_RD;
         end
         S_NBR_RD: begin
            nx_in = st.x;  ny_in = st.y;
            node_raddr = cell_addr(st.x, st.y);
            if (st.ok && open_ff[side_ff]) begin
               state_in = S_NBR_WR;
            end else if (side_ff == SIDE_WEST) begin
               bd_in = DIST_INF;  any_in = 1'b0;
               state_in = S_SCAN;
            end else begin
               side_in = side_ff + 2'd1;
            end
         end
         S_NBR_WR: begin
            // relax: shorter unsaturated distance wins
            if (!node_rdata_ff.settled && alt < {1'b0, DIST_INF}
                && alt < {1'b0, node_rdata_ff.distance}) begin
               node_we    = 1'b1;
               node_waddr = cell_addr(nx_ff, ny_ff);
               node_wdata.settled    = 1'b0;
               node_wdata.pred_valid = 1'b1;
               node_wdata.pred_side  = side_ff;
               node_wdata.distance   = alt[DIST_W-1:0];
            end
            if (side_ff == SIDE_WEST) begin
               bd_in = DIST_INF;  any_in = 1'b0;
               state_in = S_SCAN;
            end else begin
               side_in  = side_ff + 2'd1;
               state_in = S_NBR_RD;
            end
         end
         S_TRC_RD: begin
            node_raddr = cell_addr(bx_ff, by_ff);
            state_in   = S_TRC_WR;
         end
         S_TRC_WR: begin
            // walk back from target, storing arrival sides
            st = step_cell(bx_ff, by_ff, node_rdata_ff.pred_side ^ 2'd1);
            if (node_rdata_ff.pred_valid && int'(len_ff) < CELL_COUNT) begin
               path_we    = 1'b1;
               path_wdata = node_rdata_ff.pred_side;
               len_in     = len_ff + 1'b1;
               bx_in = st.x;  by_in = st.y;
               state_in = st.ok ? S_TRC_RD : S_EMIT_RD;
            end else begin
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            if (len_ff == '0) begin
               state_in = S_SELECT;
            end else begin
               len_in   = len_dec;
               sub_in   = 2'd0;
               state_in = S_EMIT;
               pend_in  = 1'b1;
            end
         end
         S_EMIT: begin
            // with pend_ff set, load the step from the path store
            if (pend_ff) begin
               pend_in = 1'b0;
               dir_in  = path_rdata_ff;
               kind_in = move_kind(path_rdata_ff, head_ff);
            end else begin
               if (int'(total_ff) < ACTION_DEPTH) begin
                  act_we   = 1'b1;
                  total_in = total_ff + 1'b1;
               end
               if (emit_last) begin
                  head_in  = dir_ff;
                  state_in = S_EMIT_RD;
               end else begin
                  sub_in = sub_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         x_ff         <= '0;
         y_ff         <= '0;
         ev_valid_ff  <= 1'b0;
         any_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         ev_valid_ff  <= ev_valid_in;
         any_ff       <= any_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_x_ff <= ev_x_in;  ev_y_ff <= ev_y_in;
      bd_ff <= bd_in;  bx_ff <= bx_in;  by_ff <= by_in;  bw_ff <= bw_in;
      side_ff <= side_in;  open_ff <= open_in;  nx_ff <= nx_in;  ny_ff <= ny_in;
      len_ff <= len_in;  head_ff <= head_in;  dir_ff <= dir_in;
      sub_ff <= sub_in;  kind_ff <= kind_in;
      sx_ff <= sx_in;  sy_ff <= sy_in;  tx_ff <= tx_in;  ty_ff <= ty_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;  wside_ff <= wside_in;  idx_ff <= idx_in;
      code_ff <= code_in;  rsp_ff <= rsp_in;
   end

endmodule

// ----- test/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gmp_pkg::*;

   localparam int DIM       = 16;
   localparam int CELLS     = DIM * DIM;
   localparam int UNREACHED = 511;
   localparam int MAX_ACTS  = 512;
   localparam int RANDOM_CMDS = 80;
   // allow every command to be a full-grid search, many times over
   localparam int CYCLE_LIMIT = 40_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gmp_req_if req_bus ();
   gmp_rsp_if rsp_bus ();

   grid_maze_path_planner dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Maze model: passage bits per cell, stored moves, latest plan status
   // ---------------------------------------------------------------------
   logic [3:0] open_sides [CELLS];
   logic [1:0] move_log [MAX_ACTS];
   int         move_total;
   bit         goal_found;

   // neighbor across one side; 0 if it falls off the grid
   function automatic bit neighbor(int x, int y, int s, output int nx, output int ny);
      nx = x;
      ny = y;
      case (s)
         SIDE_NORTH: begin ny = y + 1; return y + 1 < DIM; end
         SIDE_SOUTH: begin ny = y - 1; return y > 0; end
         SIDE_EAST:  begin nx = x + 1; return x + 1 < DIM; end
         default:    begin nx = x - 1; return x > 0; end
      endcase
   endfunction

   function automatic void reopen_all();
      int nx, ny;
      for (int x = 0; x < DIM; x++)
         for (int y = 0; y < DIM; y++)
            for (int s = 0; s < 4; s++)
               open_sides[x*DIM+y][s] = neighbor(x, y, s, nx, ny);
   endfunction

   function automatic void log_move(logic [1:0] code);
      if (move_total < MAX_ACTS) begin
         move_log[move_total] = code;
         move_total++;
      end
   endfunction

   // turn, then step, toward dir while facing head
   function automatic void log_step(int dir, int head);
      kind_type k;
      if (dir == head) k = KIND_FWD;
      else if (dir == (head ^ 1)) k = KIND_BACK;
      else if ((dir == SIDE_NORTH && head == SIDE_EAST) ||
               (dir == SIDE_SOUTH && head == SIDE_WEST) ||
               (dir == SIDE_EAST && head == SIDE_SOUTH) ||
               (dir == SIDE_WEST && head == SIDE_NORTH)) k = KIND_LEFT;
      else k = KIND_RIGHT;
      case (k)
         KIND_FWD:  log_move(MOVE_FWD);
         KIND_BACK: begin log_move(MOVE_RIGHT); log_move(MOVE_RIGHT); log_move(MOVE_FWD); end
         KIND_LEFT: begin log_move(MOVE_LEFT); log_move(MOVE_FWD); end
         default:   begin log_move(MOVE_RIGHT); log_move(MOVE_FWD); end
      endcase
   endfunction

   function automatic void plan_route(int sx, int sy, int tx, int ty, int head);
      int  reach_dist [CELLS];
      bit  done [CELLS];
      bit  came_valid [CELLS];
      int  came_side [CELLS];
      int  trail [MAX_ACTS];
      int  len, best, bx, by, bd, nx, ny, v, x, y, c;
      bit  any;
      for (int i = 0; i < MAX_ACTS; i++) move_log[i] = MOVE_NONE;
      move_total = 0;
      goal_found = 0;
      for (int i = 0; i < CELLS; i++) begin
         reach_dist[i] = UNREACHED;
         done[i] = 0;
         came_valid[i] = 0;
         came_side[i] = 0;
      end
      reach_dist[sx*DIM+sy] = 0;
      forever begin
         bd = UNREACHED;
         any = 0;
         best = 0; bx = 0; by = 0;
         // lowest distance wins; strict compare keeps lowest x, then lowest y
         for (int xi = 0; xi < DIM; xi++)
            for (int yi = 0; yi < DIM; yi++) begin
               c = xi*DIM + yi;
               if (!done[c] && reach_dist[c] < bd) begin
                  bd = reach_dist[c]; best = c; bx = xi; by = yi; any = 1;
               end
            end
         if (!any) break;
         done[best] = 1;
         if (bx == tx && by == ty) begin
            goal_found = 1;
            break;
         end
         for (int s = 0; s < 4; s++) begin
            if (!open_sides[best][s]) continue;
            if (!neighbor(bx, by, s, nx, ny)) continue;
            v = nx*DIM + ny;
            if (done[v] || bd + 1 >= UNREACHED) continue;
            if (bd + 1 < reach_dist[v]) begin
               reach_dist[v] = bd + 1;
               came_valid[v] = 1;
               came_side[v] = s;
            end
         end
      end
      if (!goal_found) return;
      // walk back from the target, then replay forward
      len = 0;
      x = tx; y = ty;
      while (len < MAX_ACTS) begin
         c = x*DIM + y;
         if (!came_valid[c]) break;
         trail[len++] = came_side[c];
         if (!neighbor(x, y, came_side[c] ^ 1, nx, ny)) break;
         x = nx; y = ny;
      end
      while (len > 0) begin
         len--;
         log_step(trail[len], head);
         head = trail[len];
      end
   endfunction

   function automatic rsp_payload_type apply_command(req_payload_type cmd);
      rsp_payload_type r;
      int nx, ny;
      r.move_code = MOVE_NONE;
      case (op_type'(cmd.operation))
         OP_REOPEN: reopen_all();
         OP_WALL: begin
            open_sides[cmd.cell_x*DIM+cmd.cell_y][cmd.wall_side] = 1'b0;
            if (neighbor(cmd.cell_x, cmd.cell_y, cmd.wall_side, nx, ny))
               open_sides[nx*DIM+ny][cmd.wall_side ^ 2'd1] = 1'b0;
         end
         OP_PLAN: plan_route(cmd.source_x, cmd.source_y, cmd.target_x, cmd.target_y,
                             cmd.heading);
         default: r.move_code = move_log[cmd.action_index];
      endcase
      r.action_count   = 10'(move_total);
      r.target_reached = goal_found;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Scoreboard
   // ---------------------------------------------------------------------
   rsp_payload_type pending_rsp [$];
   bit              cur_typed;
   rsp_payload_type cur_want;
   int              mismatches = 0;
   bit              failed = 0;
   int              cycles = 0;

   always @(posedge clock) begin
      rsp_payload_type got, want, calc;
      // push the expectation of each accepted command
      if (!reset && req_bus.valid && req_bus.ready) begin
         calc = apply_command(req_bus.payload);
         pending_rsp.push_back(cur_typed ? cur_want : calc);
      end
      // compare each accepted result with the oldest expectation
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.payload;
         if (pending_rsp.size() == 0) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response count=%0d reached=%0b move=%0d",
                        got.action_count, got.target_reached, got.move_code);
         end else begin
            want = pending_rsp.pop_front();
            if (got.action_count !== want.action_count ||
                got.target_reached !== want.target_reached ||
                got.move_code !== want.move_code) begin
               failed = 1;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp count=%0d reached=%0b move=%0d, got %0d %0b %0d",
                           want.action_count, want.target_reached, want.move_code,
                           got.action_count, got.target_reached, got.move_code);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL grid_maze_path_planner");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stall on a random mask, sometimes wide open
   // ---------------------------------------------------------------------
   initial begin
      logic [15:0] stall_mask;
      rsp_bus.ready = 1'b0;
      forever begin
         stall_mask = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
         for (int i = 0; i < 16; i++) begin
            @(negedge clock);
            rsp_bus.ready = stall_mask[i];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------
   int burst_left = 0;

   // drive one transaction and hold it until accepted
   task automatic send_cmd(req_payload_type cmd, bit typed, rsp_payload_type want);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      req_bus.valid   = 1'b1;
      req_bus.payload = cmd;
      cur_typed = typed;
      cur_want  = want;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   // hold off until every expected response has come back
   task automatic drain();
      req_bus.valid = 1'b0;
      burst_left = 0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // random filler in fields the operation does not use
   function automatic req_payload_type make_cmd(op_type op, int cx, int cy, int side,
                                                int sx, int sy, int tx, int ty,
                                                int head, int idx);
      req_payload_type c;
      c = req_payload_type'($bits(req_payload_type)'({$urandom, $urandom}));
      c.operation = op;
      if (op == OP_WALL) begin
         c.cell_x = 4'(cx); c.cell_y = 4'(cy); c.wall_side = 2'(side);
      end
      if (op == OP_PLAN) begin
         c.source_x = 4'(sx); c.source_y = 4'(sy); c.target_x = 4'(tx); c.target_y = 4'(ty);
         c.heading = 2'(head);
      end
      if (op == OP_READ) c.action_index = 9'(idx);
      return c;
   endfunction

   function automatic rsp_payload_type resp(int count, bit reached, logic [1:0] move);
      rsp_payload_type r;
      r.action_count = 10'(count);
      r.target_reached = reached;
      r.move_code = move;
      return r;
   endfunction

   typedef struct {
      req_payload_type cmd;
      bit              typed;
      rsp_payload_type want;
   } vector_type;

   vector_type directed [$];

   function automatic void add_vec(req_payload_type cmd, bit typed = 0,
                                   rsp_payload_type want = '0);
      vector_type v;
      v.cmd = cmd;
      v.typed = typed;
      v.want = want;
      directed.push_back(v);
   endfunction

   function automatic int clamp(int v);
      return (v < 0) ? 0 : (v > DIM - 1) ? DIM - 1 : v;
   endfunction

   initial begin
      req_payload_type cmd;
      int pick, sx, sy;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      cur_typed = 0;
      cur_want = '0;
      reopen_all();
      for (int i = 0; i < MAX_ACTS; i++) move_log[i] = MOVE_NONE;
      move_total = 0;
      goal_found = 0;

      // nothing planned yet: reads are empty at both ends of the store
      add_vec(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, resp(0, 0, MOVE_NONE));
      add_vec(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 511), 1, resp(0, 0, MOVE_NONE));
      // source on target: found, no moves
      add_vec(make_cmd(OP_PLAN, 0, 0, 0, 5, 5, 5, 5, SIDE_NORTH, 0), 1,
              resp(0, 1, MOVE_NONE));
      // corner to corner, full-grid search
      add_vec(make_cmd(OP_PLAN, 0, 0, 0, 0, 0, 15, 15, SIDE_NORTH, 0));
      add_vec(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_vec(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 29));
      add_vec(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 30));
      // border walls clear only their own side; then box in the origin cell
      add_vec(make_cmd(OP_WALL, 0, 0, SIDE_WEST, 0, 0, 0, 0, 0, 0));
      add_vec(make_cmd(OP_WALL, 15, 15, SIDE_NORTH, 0, 0, 0, 0, 0, 0));
      add_vec(make_cmd(OP_WALL, 0, 0, SIDE_EAST, 0, 0, 0, 0, 0, 0));
      add_vec(make_cmd(OP_WALL, 0, 0, SIDE_NORTH, 0, 0, 0, 0, 0, 0));
      // unreachable target, then unreachable from a boxed-in source
      add_vec(make_cmd(OP_PLAN, 0, 0, 0, 3, 3, 0, 0, SIDE_SOUTH, 0), 1,
              resp(0, 0, MOVE_NONE));
      add_vec(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, resp(0, 0, MOVE_NONE));
      add_vec(make_cmd(OP_PLAN, 0, 0, 0, 0, 0, 2, 1, SIDE_EAST, 0), 1,
              resp(0, 0, MOVE_NONE));
      add_vec(make_cmd(OP_REOPEN, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, resp(0, 0, MOVE_NONE));
      // detours around interior walls, every turn kind
      add_vec(make_cmd(OP_WALL, 7, 7, SIDE_SOUTH, 0, 0, 0, 0, 0, 0));
      add_vec(make_cmd(OP_WALL, 8, 8, SIDE_WEST, 0, 0, 0, 0, 0, 0));
      add_vec(make_cmd(OP_PLAN, 0, 0, 0, 7, 8, 7, 6, SIDE_WEST, 0));
      add_vec(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 2));
      add_vec(make_cmd(OP_PLAN, 0, 0, 0, 4, 4, 4, 3, SIDE_NORTH, 0));
      add_vec(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_vec(make_cmd(OP_PLAN, 0, 0, 0, 9, 9, 8, 9, SIDE_SOUTH, 0));
      add_vec(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         send_cmd(directed[i].cmd, directed[i].typed, directed[i].want);
      drain();

      // random part: mostly short plans so each search settles few cells
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         pick = $urandom_range(0, 99);
         sx = $urandom_range(0, DIM - 1);
         sy = $urandom_range(0, DIM - 1);
         if (pick < 5)
            cmd = make_cmd(OP_REOPEN, 0, 0, 0, 0, 0, 0, 0, 0, 0);
         else if (pick < 40)
            cmd = make_cmd(OP_WALL, sx, sy, $urandom_range(0, 3), 0, 0, 0, 0, 0, 0);
         else if (pick < 62)
            cmd = make_cmd(OP_PLAN, 0, 0, 0, sx, sy,
                           clamp(sx + $urandom_range(0, 6) - 3),
                           clamp(sy + $urandom_range(0, 6) - 3),
                           $urandom_range(0, 3), 0);
         else if (pick < 65)
            cmd = make_cmd(OP_PLAN, 0, 0, 0, sx, sy, $urandom_range(0, DIM - 1),
                           $urandom_range(0, DIM - 1), $urandom_range(0, 3), 0);
         else if (pick < 90)
            cmd = make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, $urandom_range(0, 15));
         else
            cmd = make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, $urandom_range(0, 511));
         send_cmd(cmd, 0, '0);
         if (n == RANDOM_CMDS / 2) drain();
      end
      drain();
      repeat (20) @(negedge clock);

      if (!failed && pending_rsp.size() == 0)
         $display("PASS grid_maze_path_planner");
      else
         $display("FAIL grid_maze_path_planner");
      $finish;
   end

endmodule
